FILE: rtl/irra_pkg.sv
package irra_pkg;

   // field widths
   localparam int ADDR_W    = 32;
   localparam int PROTO_W   = 8;
   localparam int FLAGS_W   = 8;
   localparam int BYTES_W   = 32;
   localparam int PKTS_W    = 24;
   localparam int SECS_W    = 16;
   localparam int RATE_W    = 51;
   localparam int TOTAL_W   = 48;
   localparam int DIR_W     = 2;
   localparam int KIND_W    = 3;
   localparam int LIMIT_W   = 32;
   localparam int FLAP_W    = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // bytes are reported as bits: times 8
   localparam int BYTE_SHIFT = 3;

   localparam logic OP_PACKET   = 1'b0;
   localparam logic OP_INTERVAL = 1'b1;

   localparam logic [KIND_W-1:0] KIND_BYTES   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PACKETS = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SYN     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UDP     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ICMP    = 3'd4;

   localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
   localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;
   localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
   localparam int FLAG_SYN_BIT = 1;
   localparam int FLAG_ACK_BIT = 4;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_RULE_DIRECTION = 3'd0;
   localparam logic [2:0] REG_RULE_MASK      = 3'd1;
   localparam logic [2:0] REG_RULE_PREFIX    = 3'd2;
   localparam logic [2:0] REG_COUNT_KIND     = 3'd3;
   localparam logic [2:0] REG_HARD_LIMIT     = 3'd4;
   localparam logic [2:0] REG_SAFE_LIMIT     = 3'd5;
   localparam logic [2:0] REG_FLAP_RELOAD    = 3'd6;

   localparam logic [DIR_W-1:0]   RST_RULE_DIRECTION = 2'd2;
   localparam logic [ADDR_W-1:0]  RST_RULE_MASK      = '0;
   localparam logic [ADDR_W-1:0]  RST_RULE_PREFIX    = '0;
   localparam logic [KIND_W-1:0]  RST_COUNT_KIND     = KIND_PACKETS;
   localparam logic [LIMIT_W-1:0] RST_HARD_LIMIT     = '1;
   localparam logic [LIMIT_W-1:0] RST_SAFE_LIMIT     = '1;
   localparam logic [FLAP_W-1:0]  RST_FLAP_RELOAD    = 8'd3;

   typedef enum logic [1:0] {
      BAND_BELOW = 2'd0,
      BAND_SAFE  = 2'd1,
      BAND_HARD  = 2'd2,
      BAND_NONE  = 2'd3
   } band_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic                 operation;
      logic                 direction;
      logic [ADDR_W-1:0]    local_addr;
      logic [PROTO_W-1:0]   protocol;
      logic [FLAGS_W-1:0]   tcp_flags;
      logic [BYTES_W-1:0]   byte_count;
      logic [PKTS_W-1:0]    packet_count;
      logic [SECS_W-1:0]    elapsed_seconds;
   } req_type;

   typedef struct packed {
      logic                 matched;
      logic                 alarm;
      logic [1:0]           band;
      logic [RATE_W-1:0]    rate;
   } rsp_type;

   typedef struct packed {
      logic [DIR_W-1:0]     rule_direction;
      logic [ADDR_W-1:0]    rule_mask;
      logic [ADDR_W-1:0]    rule_prefix;
      logic [KIND_W-1:0]    count_kind;
      logic [LIMIT_W-1:0]   hard_limit;
      logic [LIMIT_W-1:0]   safe_limit;
      logic [FLAP_W-1:0]    flap_reload;
   } cfg_type;

endpackage

FILE: rtl/irra_req_if.sv
interface irra_req_if;
   logic                  valid;
   logic                  ready;
   irra_pkg::req_type     payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/irra_rsp_if.sv
interface irra_rsp_if;
   logic                  valid;
   logic                  ready;
   irra_pkg::rsp_type     payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/ip_rule_rate_alarm.sv
// Packet event: accepted in ST_IDLE, then evaluated and counted in ST_EVAL.
// Interval end with nonzero seconds: accepted, then run in ST_RUN on the
//   bit-serial rate divider; the limit products run alongside it.
// One item in flight; the result register lets the next item be taken while
//   a result waits. Reset (synchronous): total, flap counter, control cleared.
module ip_rule_rate_alarm (
   input  logic                                clock,
   input  logic                                reset,
   irra_req_if.sink                            req_ch,
   irra_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [irra_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [irra_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [irra_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int PROD_W = irra_pkg::LIMIT_W + irra_pkg::SECS_W;

   irra_pkg::cfg_type    cfg;
   irra_pkg::state_type  state_ff, state_in;
   irra_pkg::req_type    item_ff;
   irra_pkg::rsp_type    out_ff, res;

   logic                                out_valid_ff;
   logic [irra_pkg::TOTAL_W-1:0]        total_ff, total_in;
   logic [irra_pkg::FLAP_W-1:0]         flaps_ff, flaps_in;

   logic                                slot_free;
   logic                                load_out;
   logic                                start;
   logic                                dir_ok, addr_ok, proto_ok, pkt_match;
   logic [irra_pkg::TOTAL_W-1:0]        amount;
   logic [irra_pkg::TOTAL_W:0]          sum;
   logic [irra_pkg::RATE_W-1:0]         dividend;
   logic [PROD_W-1:0]                   hard_prod, safe_prod;
   logic [irra_pkg::RATE_W-1:0]         quotient;
   logic                                hard_busy, safe_busy, div_busy;
   logic                                ge_hard, ge_safe;

   // ---------------------------------------------------------------- registers
   irra_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------------------------------------------------------- match
   // direction codes 2 and 3 both mean either direction
   assign dir_ok  = cfg.rule_direction[1] | (cfg.rule_direction[0] == item_ff.direction);
   assign addr_ok = ((item_ff.local_addr & cfg.rule_mask) == cfg.rule_prefix);

   always_comb begin
      proto_ok = 1'b0;
      amount   = irra_pkg::TOTAL_W'(item_ff.packet_count);
      case (cfg.count_kind)
         irra_pkg::KIND_BYTES: begin
            proto_ok = 1'b1;
            amount   = irra_pkg::TOTAL_W'(item_ff.byte_count);
         end
         irra_pkg::KIND_PACKETS: begin
            proto_ok = 1'b1;
         end
         irra_pkg::KIND_SYN: begin
            // bare SYN: SYN set, ACK clear; counts one per event
            proto_ok = (item_ff.protocol == irra_pkg::PROTO_TCP)
                     & item_ff.tcp_flags[irra_pkg::FLAG_SYN_BIT]
                     & ~item_ff.tcp_flags[irra_pkg::FLAG_ACK_BIT];
            amount   = irra_pkg::TOTAL_W'(1);
         end
         irra_pkg::KIND_UDP: begin
            proto_ok = (item_ff.protocol == irra_pkg::PROTO_UDP);
         end
         irra_pkg::KIND_ICMP: begin
            proto_ok = (item_ff.protocol == irra_pkg::PROTO_ICMP);
         end
         default: begin
            proto_ok = 1'b0;   // unused kinds count nothing
         end
      endcase
   end

   assign pkt_match = dir_ok & addr_ok & proto_ok;
   assign sum       = {1'b0, total_ff} + {1'b0, amount};

   // ---------------------------------------------------------------- interval math
   assign dividend = (cfg.count_kind == irra_pkg::KIND_BYTES)
                   ? (irra_pkg::RATE_W'(total_ff) << irra_pkg::BYTE_SHIFT)
                   : irra_pkg::RATE_W'(total_ff);

   irra_mul #(
      .A_W (irra_pkg::LIMIT_W),
      .B_W (irra_pkg::SECS_W)
   ) u_mul_hard (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .a       (cfg.hard_limit),
      .b       (item_ff.elapsed_seconds),
      .busy    (hard_busy),
      .product (hard_prod)
   );

   irra_mul #(
      .A_W (irra_pkg::LIMIT_W),
      .B_W (irra_pkg::SECS_W)
   ) u_mul_safe (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .a       (cfg.safe_limit),
      .b       (item_ff.elapsed_seconds),
      .busy    (safe_busy),
      .product (safe_prod)
   );

   irra_div #(
      .N_W (irra_pkg::RATE_W),
      .D_W (irra_pkg::SECS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend (dividend),
      .divisor  (item_ff.elapsed_seconds),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // products are 48 bits, same as the total
   assign ge_hard = (PROD_W'(total_ff) >= hard_prod);
   assign ge_safe = (PROD_W'(total_ff) >= safe_prod);

   // ---------------------------------------------------------------- result and state update
   always_comb begin
      res      = '0;
      res.band = irra_pkg::BAND_NONE;
      total_in = total_ff;
      flaps_in = flaps_ff;
      if (item_ff.operation == irra_pkg::OP_PACKET) begin
         if (pkt_match) begin
            res.matched = 1'b1;
            total_in    = sum[irra_pkg::TOTAL_W] ? '1 : sum[irra_pkg::TOTAL_W-1:0];
         end
      end else if (item_ff.elapsed_seconds != '0) begin
         if (ge_hard) begin
            res.band  = irra_pkg::BAND_HARD;
            res.alarm = 1'b1;
            flaps_in  = cfg.flap_reload;
         end else if (ge_safe) begin
            res.band = irra_pkg::BAND_SAFE;
            if (flaps_ff != '0) begin
               res.alarm = 1'b1;
               flaps_in  = cfg.flap_reload;
            end
         end else begin
            res.band = irra_pkg::BAND_BELOW;
            if (flaps_ff != '0) begin
               res.alarm = 1'b1;
               flaps_in  = flaps_ff - irra_pkg::FLAP_W'(1);
            end
         end
         res.rate = quotient;
         total_in = '0;
      end
   end

   // ---------------------------------------------------------------- control
   assign slot_free = ~out_valid_ff | rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      start        = 1'b0;
      load_out     = 1'b0;
      case (state_ff)
         irra_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = irra_pkg::ST_EVAL;
            end
         end
         irra_pkg::ST_EVAL: begin
            // packets and zero-second intervals finish here
            if ((item_ff.operation == irra_pkg::OP_PACKET) ||
                (item_ff.elapsed_seconds == '0)) begin
               if (slot_free) begin
                  load_out = 1'b1;
                  state_in = irra_pkg::ST_IDLE;
               end
            end else begin
               start    = 1'b1;
               state_in = irra_pkg::ST_RUN;
            end
         end
         irra_pkg::ST_RUN: begin
            if (~hard_busy & ~safe_busy & ~div_busy & slot_free) begin
               load_out = 1'b1;
               state_in = irra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = irra_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= irra_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         total_ff     <= '0;
         flaps_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
            total_ff     <= total_in;
            flaps_ff     <= flaps_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid & req_ch.ready) begin
         item_ff <= req_ch.payload;
      end
      if (load_out) begin
         out_ff <= res;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_ff;

endmodule

FILE: rtl/irra_csr.sv
module irra_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [irra_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [irra_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [irra_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output irra_pkg::cfg_type                   cfg
);

   irra_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rule_direction <= irra_pkg::RST_RULE_DIRECTION;
         cfg_ff.rule_mask      <= irra_pkg::RST_RULE_MASK;
         cfg_ff.rule_prefix    <= irra_pkg::RST_RULE_PREFIX;
         cfg_ff.count_kind     <= irra_pkg::RST_COUNT_KIND;
         cfg_ff.hard_limit     <= irra_pkg::RST_HARD_LIMIT;
         cfg_ff.safe_limit     <= irra_pkg::RST_SAFE_LIMIT;
         cfg_ff.flap_reload    <= irra_pkg::RST_FLAP_RELOAD;
      end else if (wr_en) begin
         case (reg_idx)
            irra_pkg::REG_RULE_DIRECTION: begin
               cfg_ff.rule_direction <= csr_pwdata[irra_pkg::DIR_W-1:0];
            end
            irra_pkg::REG_RULE_MASK: begin
               cfg_ff.rule_mask <= csr_pwdata[irra_pkg::ADDR_W-1:0];
            end
            irra_pkg::REG_RULE_PREFIX: begin
               cfg_ff.rule_prefix <= csr_pwdata[irra_pkg::ADDR_W-1:0];
            end
            irra_pkg::REG_COUNT_KIND: begin
               cfg_ff.count_kind <= csr_pwdata[irra_pkg::KIND_W-1:0];
            end
            irra_pkg::REG_HARD_LIMIT: begin
               cfg_ff.hard_limit <= csr_pwdata[irra_pkg::LIMIT_W-1:0];
            end
            irra_pkg::REG_SAFE_LIMIT: begin
               cfg_ff.safe_limit <= csr_pwdata[irra_pkg::LIMIT_W-1:0];
            end
            irra_pkg::REG_FLAP_RELOAD: begin
               cfg_ff.flap_reload <= csr_pwdata[irra_pkg::FLAP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_idx)
         irra_pkg::REG_RULE_DIRECTION: begin
            csr_prdata = irra_pkg::CSR_DATA_W'(cfg_ff.rule_direction);
         end
         irra_pkg::REG_RULE_MASK: begin
            csr_prdata = irra_pkg::CSR_DATA_W'(cfg_ff.rule_mask);
         end
         irra_pkg::REG_RULE_PREFIX: begin
            csr_prdata = irra_pkg::CSR_DATA_W'(cfg_ff.rule_prefix);
         end
         irra_pkg::REG_COUNT_KIND: begin
            csr_prdata = irra_pkg::CSR_DATA_W'(cfg_ff.count_kind);
         end
         irra_pkg::REG_HARD_LIMIT: begin
            csr_prdata = irra_pkg::CSR_DATA_W'(cfg_ff.hard_limit);
         end
         irra_pkg::REG_SAFE_LIMIT: begin
            csr_prdata = irra_pkg::CSR_DATA_W'(cfg_ff.safe_limit);
         end
         irra_pkg::REG_FLAP_RELOAD: begin
            csr_prdata = irra_pkg::CSR_DATA_W'(cfg_ff.flap_reload);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

endmodule

FILE: rtl/irra_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
module irra_mul #(
   parameter int A_W = irra_pkg::LIMIT_W,
   parameter int B_W = irra_pkg::SECS_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [A_W-1:0]       a,
   input  logic [B_W-1:0]       b,
   output logic                 busy,
   output logic [A_W+B_W-1:0]   product
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [A_W-1:0]   a_ff;
   logic [B_W-1:0]   b_ff;
   logic [A_W-1:0]   hi_ff;
   logic [B_W-1:0]   lo_ff;
   logic [A_W-1:0]   addend;
   logic [A_W:0]     sum;

   assign addend  = b_ff[0] ? a_ff : '0;
   assign sum     = {1'b0, hi_ff} + {1'b0, addend};
   assign busy    = busy_ff;
   assign product = {hi_ff, lo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(B_W);
      end else if (busy_ff) begin
         busy_ff <= (cnt_ff != CNT_W'(1));
         cnt_ff  <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= a;
         b_ff  <= b;
         hi_ff <= '0;
         lo_ff <= '0;
      end else if (busy_ff) begin
         hi_ff <= sum[A_W:1];
         lo_ff <= {sum[0], lo_ff[B_W-1:1]};
         b_ff  <= b_ff >> 1;
      end
   end

endmodule

FILE: rtl/irra_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
// Divisor must be nonzero.
module irra_div #(
   parameter int N_W = irra_pkg::RATE_W,
   parameter int D_W = irra_pkg::SECS_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [N_W-1:0]     dividend,
   input  logic [D_W-1:0]     divisor,
   output logic               busy,
   output logic [N_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [N_W-1:0]   q_ff;
   logic [D_W-1:0]   rem_ff;
   logic [D_W-1:0]   d_ff;
   logic [D_W:0]     trial;
   logic [D_W:0]     diff;
   logic             fits;

   assign trial    = {rem_ff, q_ff[N_W-1]};
   assign diff     = trial - {1'b0, d_ff};
   assign fits     = (trial >= {1'b0, d_ff});
   assign busy     = busy_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(N_W);
      end else if (busy_ff) begin
         busy_ff <= (cnt_ff != CNT_W'(1));
         cnt_ff  <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         d_ff   <= divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so D_W bits hold it
         rem_ff <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
         q_ff   <= {q_ff[N_W-2:0], fits};
      end
   end

endmodule

FILE: tb/rate_alarm_checker.sv
`timescale 1ns / 1ps
module rate_alarm_checker (
   input  logic                            clock,
   input  logic                            reset,
   irra_req_if                             req_ch,
   irra_rsp_if                             rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [irra_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [irra_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                            csr_pready,
   output int                              mismatch_count,
   output int                              verdicts_owed,
   output int                              verdicts_checked,
   output int                              alarms_seen
);
   import irra_pkg::*;

   localparam logic [TOTAL_W-1:0] TALLY_MAX = '1;

   cfg_type            rule_cfg;
   logic [TOTAL_W-1:0] rule_tally;
   logic [FLAP_W-1:0]  flap_count;
   rsp_type            pending_verdicts[$];

   initial begin
      mismatch_count   = 0;
      verdicts_owed    = 0;
      verdicts_checked = 0;
      alarms_seen      = 0;
   end

   function automatic logic packet_counts(input req_type item);
      logic dir_ok;
      logic proto_ok;
      dir_ok = rule_cfg.rule_direction[1] || (rule_cfg.rule_direction[0] == item.direction);
      case (rule_cfg.count_kind)
         KIND_BYTES, KIND_PACKETS: proto_ok = 1'b1;
         KIND_SYN: proto_ok = (item.protocol == PROTO_TCP) && item.tcp_flags[FLAG_SYN_BIT]
                              && !item.tcp_flags[FLAG_ACK_BIT];
         KIND_UDP:  proto_ok = (item.protocol == PROTO_UDP);
         KIND_ICMP: proto_ok = (item.protocol == PROTO_ICMP);
         default:   proto_ok = 1'b0;
      endcase
      return dir_ok && proto_ok
             && ((item.local_addr & rule_cfg.rule_mask) == rule_cfg.rule_prefix);
   endfunction

   // updates tally and flap counter as the block does
   function automatic rsp_type predict_verdict(input req_type item);
      rsp_type            verdict;
      logic [TOTAL_W:0]   sum;
      logic [TOTAL_W-1:0] amount;
      logic [TOTAL_W-1:0] hard_bar;
      logic [TOTAL_W-1:0] safe_bar;
      logic [RATE_W-1:0]  scaled;
      verdict.matched = 1'b0;
      verdict.alarm   = 1'b0;
      verdict.band    = BAND_NONE;
      verdict.rate    = '0;
      if (item.operation == OP_PACKET) begin
         if (packet_counts(item)) begin
            if (rule_cfg.count_kind == KIND_BYTES) amount = TOTAL_W'(item.byte_count);
            else if (rule_cfg.count_kind == KIND_SYN) amount = TOTAL_W'(1);
            else amount = TOTAL_W'(item.packet_count);
            sum = {1'b0, rule_tally} + {1'b0, amount};
            rule_tally = sum[TOTAL_W] ? TALLY_MAX : sum[TOTAL_W-1:0];
            verdict.matched = 1'b1;
         end
      end else if (item.elapsed_seconds != '0) begin
         hard_bar = TOTAL_W'(rule_cfg.hard_limit) * TOTAL_W'(item.elapsed_seconds);
         safe_bar = TOTAL_W'(rule_cfg.safe_limit) * TOTAL_W'(item.elapsed_seconds);
         if (rule_tally >= hard_bar) begin
            verdict.band  = BAND_HARD;
            verdict.alarm = 1'b1;
            flap_count    = rule_cfg.flap_reload;
         end else if (rule_tally >= safe_bar) begin
            verdict.band = BAND_SAFE;
            if (flap_count != '0) begin
               verdict.alarm = 1'b1;
               flap_count    = rule_cfg.flap_reload;
            end
         end else begin
            verdict.band = BAND_BELOW;
            if (flap_count != '0) begin
               verdict.alarm = 1'b1;
               flap_count    = flap_count - 1'b1;
            end
         end
         scaled = RATE_W'(rule_tally);
         if (rule_cfg.count_kind == KIND_BYTES) scaled = scaled << BYTE_SHIFT;
         verdict.rate = scaled / RATE_W'(item.elapsed_seconds);
         rule_tally   = '0;
      end
      return verdict;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rule_cfg = '{rule_direction: RST_RULE_DIRECTION, rule_mask: RST_RULE_MASK,
                      rule_prefix: RST_RULE_PREFIX, count_kind: RST_COUNT_KIND,
                      hard_limit: RST_HARD_LIMIT, safe_limit: RST_SAFE_LIMIT,
                      flap_reload: RST_FLAP_RELOAD};
         rule_tally = '0;
         flap_count = '0;
         pending_verdicts.delete();
      end else begin
         // results first: a result never belongs to the item taken at the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (pending_verdicts.size() == 0) begin
               $error("result transfer with no item outstanding: %p", got);
               mismatch_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (got.matched !== want.matched) begin
                  $error("result %0d matched: expected %0d, actual %0d",
                         verdicts_checked, want.matched, got.matched);
                  mismatch_count++;
               end
               if (got.alarm !== want.alarm) begin
                  $error("result %0d alarm: expected %0d, actual %0d",
                         verdicts_checked, want.alarm, got.alarm);
                  mismatch_count++;
               end
               if (got.band !== want.band) begin
                  $error("result %0d band: expected %0d, actual %0d",
                         verdicts_checked, want.band, got.band);
                  mismatch_count++;
               end
               if (got.rate !== want.rate) begin
                  $error("result %0d rate: expected %0d, actual %0d",
                         verdicts_checked, want.rate, got.rate);
                  mismatch_count++;
               end
               if (got.alarm === 1'b1) alarms_seen++;
               verdicts_checked++;
            end
         end
         if (req_ch.valid && req_ch.ready)
            pending_verdicts.push_back(predict_verdict(req_ch.payload));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_RULE_DIRECTION: rule_cfg.rule_direction = csr_pwdata[DIR_W-1:0];
               REG_RULE_MASK:      rule_cfg.rule_mask      = csr_pwdata[ADDR_W-1:0];
               REG_RULE_PREFIX:    rule_cfg.rule_prefix    = csr_pwdata[ADDR_W-1:0];
               REG_COUNT_KIND:     rule_cfg.count_kind     = csr_pwdata[KIND_W-1:0];
               REG_HARD_LIMIT:     rule_cfg.hard_limit     = csr_pwdata[LIMIT_W-1:0];
               REG_SAFE_LIMIT:     rule_cfg.safe_limit     = csr_pwdata[LIMIT_W-1:0];
               REG_FLAP_RELOAD:    rule_cfg.flap_reload    = csr_pwdata[FLAP_W-1:0];
               default: ;
            endcase
         end
      end
      verdicts_owed = pending_verdicts.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import irra_pkg::*;

   localparam int CLOCK_HALF     = 6;
   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int RANDOM_ITEMS   = 850;
   localparam int PHASES         = 10;
   // a short run of full-size byte records pushes the tally well past 32 bits
   localparam int LARGE_ITEMS    = 32;
   // an interval end waits on the bit-serial divider; allow some slack
   localparam int DRAIN_CYCLES   = 80;
   localparam int LONG_HOLD      = 300;
   localparam int BURST_ITEMS    = 16;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   irra_req_if req_bus ();
   irra_rsp_if rsp_bus ();

   int mismatch_count;
   int verdicts_owed;
   int verdicts_checked;
   int alarms_seen;
   int cycle_count = 0;
   int items_sent  = 0;
   int cfg_writes  = 0;

   // idling controls, flipped per phase by the stimulus
   bit sender_throttle = 1'b1;
   bit drain_throttle  = 1'b1;
   bit hold_request    = 1'b0;

   // what the registers hold now, used to aim the stimulus at the rule
   cfg_type shadow_cfg;

   ip_rule_rate_alarm i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rate_alarm_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .mismatch_count   (mismatch_count),
      .verdicts_owed    (verdicts_owed),
      .verdicts_checked (verdicts_checked),
      .alarms_seen      (alarms_seen)
   );

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // gap length in cycles: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Result side. ready changes only at the falling edge. A long hold-off is
   // counted here so the sender keeps pushing while the block backs up.
   initial begin : result_drain
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request  = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            stall_left    = 0;
            rsp_bus.ready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (drain_throttle) stall_left = pick_gap();
         end
      end
   end

   // Called at a falling edge, returns at a falling edge with valid still high,
   // so back-to-back transfers never drop valid in between.
   task automatic send_item(input req_type item);
      int gap;
      gap = sender_throttle ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.payload = item;
      req_bus.valid   = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // stop offering and wait until every result is back
   task automatic settle();
      req_bus.valid = 1'b0;
      while (verdicts_owed != 0) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle; pready is waited on anyway
   task automatic write_reg(input logic [2:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      cfg_writes++;
   endtask

   // Writes all seven registers. Narrow ones get junk in the unused upper
   // bits, which the block has to drop.
   task automatic apply_rule(input cfg_type c);
      write_reg(REG_RULE_DIRECTION, ($urandom() & ~32'h3) | 32'(c.rule_direction));
      write_reg(REG_RULE_MASK, c.rule_mask);
      write_reg(REG_RULE_PREFIX, c.rule_prefix);
      write_reg(REG_COUNT_KIND, ($urandom() & ~32'h7) | 32'(c.count_kind));
      write_reg(REG_HARD_LIMIT, c.hard_limit);
      write_reg(REG_SAFE_LIMIT, c.safe_limit);
      write_reg(REG_FLAP_RELOAD, ($urandom() & ~32'hFF) | 32'(c.flap_reload));
      shadow_cfg = c;
   endtask

   function automatic cfg_type rule_of(input logic [DIR_W-1:0] dir,
                                       input logic [ADDR_W-1:0] mask,
                                       input logic [ADDR_W-1:0] prefix,
                                       input logic [KIND_W-1:0] kind,
                                       input logic [LIMIT_W-1:0] hard,
                                       input logic [LIMIT_W-1:0] safe,
                                       input logic [FLAP_W-1:0] flap);
      return '{rule_direction: dir, rule_mask: mask, rule_prefix: prefix, count_kind: kind,
               hard_limit: hard, safe_limit: safe, flap_reload: flap};
   endfunction

   // random rule; limits scaled so all three bands show up, extremes now and then
   function automatic cfg_type random_rule();
      cfg_type c;
      int      plen;
      int      scale;
      plen = $urandom_range(0, 32);
      c.rule_direction = DIR_W'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
         0:       c.rule_mask = '0;
         1:       c.rule_mask = '1;
         default: c.rule_mask = (plen == 0) ? '0 : ~(32'hFFFF_FFFF >> plen);
      endcase
      c.rule_prefix = $urandom() & c.rule_mask;
      // occasionally a fully random prefix: with bits outside the mask nothing can match
      if ($urandom_range(0, 19) == 0) c.rule_prefix = $urandom();
      c.count_kind = ($urandom_range(0, 9) == 0) ? KIND_W'($urandom_range(5, 7))
                                                 : KIND_W'($urandom_range(0, 4));
      scale = (c.count_kind == KIND_BYTES) ? 3000 : 40;
      case ($urandom_range(0, 9))
         0:       c.hard_limit = '0;
         1:       c.hard_limit = '1;
         default: c.hard_limit = $urandom_range(1, scale);
      endcase
      case ($urandom_range(0, 9))
         0:       c.safe_limit = '0;
         1:       c.safe_limit = '1;
         2:       c.safe_limit = $urandom_range(0, scale);
         default: c.safe_limit = 32'((64'(c.hard_limit) * $urandom_range(10, 90)) / 100);
      endcase
      case ($urandom_range(0, 7))
         0:       c.flap_reload = '0;
         1:       c.flap_reload = '1;
         default: c.flap_reload = FLAP_W'($urandom_range(1, 6));
      endcase
      return c;
   endfunction

   // fully random item, either operation
   function automatic req_type noise_item();
      req_type p;
      p.operation       = 1'($urandom_range(0, 1));
      p.direction       = 1'($urandom_range(0, 1));
      p.local_addr      = $urandom();
      p.protocol        = PROTO_W'($urandom());
      p.tcp_flags       = FLAGS_W'($urandom());
      p.byte_count      = $urandom();
      p.packet_count    = PKTS_W'($urandom());
      p.elapsed_seconds = SECS_W'($urandom());
      return p;
   endfunction

   function automatic req_type make_packet(input logic dir, input logic [ADDR_W-1:0] addr,
                                           input logic [PROTO_W-1:0] proto,
                                           input logic [FLAGS_W-1:0] flags,
                                           input logic [BYTES_W-1:0] bytes,
                                           input logic [PKTS_W-1:0] pkts);
      req_type p;
      p              = noise_item();
      p.operation    = OP_PACKET;
      p.direction    = dir;
      p.local_addr   = addr;
      p.protocol     = proto;
      p.tcp_flags    = flags;
      p.byte_count   = bytes;
      p.packet_count = pkts;
      return p;
   endfunction

   // interval end; the packet fields carry junk and must be ignored
   function automatic req_type interval_end(input logic [SECS_W-1:0] secs);
      req_type p;
      p                 = noise_item();
      p.operation       = OP_INTERVAL;
      p.elapsed_seconds = secs;
      return p;
   endfunction

   // packet aimed at the current rule most of the time, with random misses
   function automatic req_type fitting_packet();
      req_type p;
      p           = noise_item();
      p.operation = OP_PACKET;
      if ($urandom_range(0, 9) < 8 && !shadow_cfg.rule_direction[1])
         p.direction = shadow_cfg.rule_direction[0];
      if ($urandom_range(0, 9) < 8)
         p.local_addr = shadow_cfg.rule_prefix | (p.local_addr & ~shadow_cfg.rule_mask);
      if ($urandom_range(0, 9) < 7) begin
         case (shadow_cfg.count_kind)
            KIND_SYN: begin
               p.protocol                  = PROTO_TCP;
               p.tcp_flags[FLAG_SYN_BIT]   = 1'b1;
               p.tcp_flags[FLAG_ACK_BIT]   = 1'b0;
            end
            KIND_UDP:  p.protocol = PROTO_UDP;
            KIND_ICMP: p.protocol = PROTO_ICMP;
            default: ;
         endcase
      end
      if ($urandom_range(0, 9) < 9) p.byte_count = $urandom_range(40, 1500);
      if ($urandom_range(0, 9) < 9) p.packet_count = PKTS_W'($urandom_range(1, 16));
      return p;
   endfunction

   function automatic logic [SECS_W-1:0] pick_seconds();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return '0;
      if (roll < 6) return SECS_W'($urandom_range(0, 65535));
      return SECS_W'($urandom_range(1, 8));
   endfunction

   // one well-formed measurement interval: some packets, then its end
   task automatic send_interval_burst();
      int n;
      n = $urandom_range(0, 12);
      repeat (n) send_item(fitting_packet());
      send_item(interval_end(pick_seconds()));
   endtask

   initial begin : stimulus
      int target;
      req_type flood;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      shadow_cfg      = rule_of(RST_RULE_DIRECTION, RST_RULE_MASK, RST_RULE_PREFIX,
                                RST_COUNT_KIND, RST_HARD_LIMIT, RST_SAFE_LIMIT,
                                RST_FLAP_RELOAD);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed: reset rule counts packets from anywhere ----
      send_item(make_packet(1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 24'hFF_FFFF));
      send_item(make_packet(1'b0, 32'h0, 8'h00, 8'h00, 32'h0, 24'h0));
      // zero seconds: no evaluation, tally must survive into the next interval
      send_item(interval_end(16'h0));
      // longest interval against the largest limits
      send_item(interval_end(16'hFFFF));

      // byte counting, direction 0 only, one /24; flap hysteresis walk-through
      settle();
      apply_rule(rule_of(2'd0, 32'hFFFF_FF00, 32'h0A00_0100, KIND_BYTES, 32'd1000, 32'd500,
                         8'd2));
      send_item(make_packet(1'b0, 32'h0A00_01FF, PROTO_TCP, 8'h10, 32'd1200, 24'd1));
      send_item(make_packet(1'b1, 32'h0A00_01FF, PROTO_TCP, 8'h10, 32'd1200, 24'd1));
      send_item(make_packet(1'b0, 32'h0A00_0200, PROTO_TCP, 8'h10, 32'd1200, 24'd1));
      send_item(interval_end(16'd1));                  // hard: alarm, reload
      send_item(interval_end(16'd1));                  // below: alarm, count down
      send_item(make_packet(1'b0, 32'h0A00_0101, PROTO_UDP, 8'h00, 32'd700, 24'd1));
      send_item(interval_end(16'd1));                  // safe band with flaps left: reload
      send_item(interval_end(16'd1));
      send_item(interval_end(16'd1));
      send_item(interval_end(16'd1));                  // flaps used up: quiet
      send_item(make_packet(1'b0, 32'h0A00_0180, PROTO_ICMP, 8'h00, 32'd600, 24'd1));
      send_item(interval_end(16'd1));                  // safe band, no flaps: quiet

      // bare SYN counting with the unused direction code; safe limit zero
      settle();
      apply_rule(rule_of(2'd3, 32'h0, 32'h0, KIND_SYN, 32'hFFFF_FFFF, 32'h0, 8'd0));
      send_item(make_packet(1'b0, $urandom(), PROTO_TCP, 8'h02, $urandom(),
                            PKTS_W'($urandom())));
      send_item(make_packet(1'b1, $urandom(), PROTO_TCP, 8'h12, $urandom(),
                            PKTS_W'($urandom())));
      send_item(make_packet(1'b1, $urandom(), PROTO_UDP, 8'h02, $urandom(),
                            PKTS_W'($urandom())));
      send_item(make_packet(1'b0, $urandom(), PROTO_TCP, 8'hED, $urandom(),
                            PKTS_W'($urandom())));
      send_item(interval_end(16'hFFFF));

      settle();
      apply_rule(rule_of(2'd2, 32'h0, 32'h0, KIND_UDP, 32'h0, 32'h0, 8'd0));
      send_item(make_packet(1'b0, $urandom(), PROTO_UDP, FLAGS_W'($urandom()), $urandom(),
                            24'd5));
      send_item(make_packet(1'b1, $urandom(), PROTO_TCP, FLAGS_W'($urandom()), $urandom(),
                            24'd5));
      settle();
      apply_rule(rule_of(2'd2, 32'h0, 32'h0, KIND_ICMP, 32'h0, 32'h0, 8'd0));
      send_item(make_packet(1'b1, $urandom(), PROTO_ICMP, FLAGS_W'($urandom()), $urandom(),
                            24'd7));
      send_item(make_packet(1'b0, $urandom(), PROTO_UDP, FLAGS_W'($urandom()), $urandom(),
                            24'd7));
      // unused count kind: nothing matches, carried tally divided without scaling
      settle();
      apply_rule(rule_of(2'd2, 32'h0, 32'h0, 3'd7, 32'h0, 32'h0, 8'd0));
      send_item(make_packet(1'b0, $urandom(), PROTO_UDP, FLAGS_W'($urandom()), $urandom(),
                            24'd9));
      send_item(interval_end(16'd3));

      // ---- large tally: back-to-back full-size byte records ----
      settle();
      apply_rule(rule_of(2'd1, 32'hFFFF_FFFF, 32'hC0A8_0001, KIND_BYTES, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 8'hFF));
      sender_throttle = 1'b0;
      drain_throttle  = 1'b0;
      flood = make_packet(1'b1, 32'hC0A8_0001, PROTO_TCP, 8'h00, 32'hFFFF_FFFF, 24'd1);
      repeat (LARGE_ITEMS) send_item(flood);
      // one second at the large tally gives a wide rate
      send_item(interval_end(16'd1));

      // ---- random phases, one rule each ----
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         apply_rule(random_rule());
         // some phases run without gaps on one side
         sender_throttle = (phase % 3) != 1;
         drain_throttle  = (phase % 4) != 2;
         if (phase == PHASES / 2) begin
            // result side holds off while the sender keeps offering
            hold_request = 1'b1;
            wait (hold_request == 1'b0);
            repeat (BURST_ITEMS) send_item(fitting_packet());
         end
         target = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < target) begin
            if ($urandom_range(0, 99) < 85) send_interval_burst();
            else send_item(noise_item());
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Run covered %0d item transfers, %0d results compared, %0d alarm reports,",
               items_sent, verdicts_checked, alarms_seen);
      $display("  %0d register writes across directed, large-tally and %0d random rules.",
               cfg_writes, PHASES);
      if (mismatch_count == 0 && verdicts_owed == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/irra_pkg.sv
rtl/irra_req_if.sv
rtl/irra_rsp_if.sv
rtl/irra_csr.sv
rtl/irra_mul.sv
rtl/irra_div.sv
rtl/ip_rule_rate_alarm.sv
tb/rate_alarm_checker.sv
tb/testbench.sv
